[hw/rtl/rcb_pkg.sv]
// Shared constants and types for the bus frame receiver.
package rcb_pkg;

  localparam int unsigned FrameBytesDef   = 64;
  localparam int unsigned ChannelCountDef = 16;
  localparam int unsigned ResultLimit     = 64;

  localparam logic [7:0]  HdrA         = 8'h3e;
  localparam logic [7:0]  HdrB         = 8'h3d;
  localparam logic [7:0]  BlkChannels  = 8'h31;
  localparam logic [7:0]  BlkTelemetry = 8'h3a;
  localparam logic [7:0]  BlkMenu      = 8'h3b;
  localparam logic [7:0]  MinLength    = 8'd6;
  localparam logic [15:0] CenterReset  = 16'd12000;
  localparam logic [15:0] CrcPoly      = 16'h8408;

  // Offsets inside a frame never exceed 9 bits (length byte plus block length).
  localparam int unsigned OffW = 9;

  typedef enum logic [1:0] {
    EvChannel   = 2'd0,
    EvTelemetry = 2'd1,
    EvMenu      = 2'd2,
    EvUnknown   = 2'd3
  } event_kind_e;

endpackage

[hw/rtl/rcb_byte_if.sv]
// Stream interfaces for received bytes and for emitted events.
interface rcb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcb_evt_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [3:0]         channel_index;
  logic signed [15:0] channel_value;
  logic [7:0]         frame_id;
  logic               last_of_run;
  modport source (output valid, output event_kind, output channel_index,
                  output channel_value, output frame_id, output last_of_run,
                  input ready);
  modport sink (input valid, input event_kind, input channel_index,
                input channel_value, input frame_id, input last_of_run,
                output ready);
endinterface

[hw/rtl/rcb_ram.sv]
// Generic single write port, single read port RAM with registered read.
module rcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/rcb_crc.sv]
// Bit-serial CRC-16/CCITT (reflected) engine, one bit per cycle.
module rcb_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        init_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o,
  output logic        busy_o
);
  import rcb_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [7:0]  sh_q, sh_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        fb;

  assign fb = crc_q[0] ^ sh_q[0];

  always_comb begin
    crc_d  = crc_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      crc_d  = init_i ? 16'h0000 : crc_q;
      sh_d   = data_i;
      cnt_d  = 3'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d  = (crc_q >> 1) ^ (fb ? CrcPoly : 16'h0000);
      sh_d   = sh_q >> 1;
      cnt_d  = cnt_q + 3'd1;
      busy_d = (cnt_q != 3'd7);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= 16'h0000;
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      crc_q  <= crc_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign crc_o  = crc_q;
  assign busy_o = busy_q;
endmodule

[hw/rtl/rc_bus_frame_receiver.sv]
// Bus frame receiver: header hunt, bit-serial CRC check and block walk to events.
// A byte inside the CRC span waits in S_CRC while the engine shifts one bit per cycle; the two
// trailing CRC bytes pass S_CRC without starting it, and a skipped non-header or rejected length
// byte stays in S_IDLE. After a good frame S_W_ID, S_W_LEN, S_W_BLK read each block, S_W_LO,
// S_W_HI, S_W_VAL each channel, S_EMIT waits for ready; no byte is taken during the walk.
// Reset clears control state and sets the channel center to 12000; the buffer is not cleared.
module rc_bus_frame_receiver #(
  parameter int unsigned FRAME_BYTES   = rcb_pkg::FrameBytesDef,
  parameter int unsigned CHANNEL_COUNT = rcb_pkg::ChannelCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  rcb_byte_if.sink    in_if,
  rcb_evt_if.source   out_if
);
  import rcb_pkg::*;

  localparam int unsigned AW = $clog2(FRAME_BYTES);

  // One-hot sequencer: byte intake, CRC wait, then the block walk.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CRC   = 9'b000000010,
    S_W_ID  = 9'b000000100,
    S_W_LEN = 9'b000001000,
    S_W_BLK = 9'b000010000,
    S_W_LO  = 9'b000100000,
    S_W_HI  = 9'b001000000,
    S_W_VAL = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]      center_q;
  logic             phase_q, phase_d;      // 0 hunting, 1 inside a frame
  logic [7:0]       count_q, count_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       fid_q, fid_d;
  logic [7:0]       prev_q, prev_d;
  logic [15:0]      rcv_q, rcv_d;
  logic             end_q, end_d;

  logic [OffW-1:0]  idx_q, idx_d;
  logic [OffW-1:0]  next_q, next_d;
  logic [7:0]       id_q, id_d;
  logic [3:0]       ch_q, ch_d;
  logic [7:0]       lo_q, lo_d;
  logic [6:0]       n_q, n_d;

  logic [1:0]       kind_q, kind_d;
  logic [15:0]      val_q, val_d;
  logic             last_q, last_d;

  logic             acc;
  logic [7:0]       b;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [OffW-1:0]  rd_addr;
  logic [7:0]       ram_rdata;
  logic             rd_ok_q;
  logic [7:0]       rbyte;
  logic             crc_start, crc_init, crc_busy;
  logic [15:0]      crc;

  logic [7:0]       len_eff;
  logic [8:0]       count_inc;
  logic [OffW-1:0]  walk_end;
  logic [OffW-1:0]  chan_addr;
  logic             at_limit;

  assign acc = in_if.valid && in_if.ready;
  assign b   = in_if.rx_byte;
  assign in_if.ready = (state_q == S_IDLE);

  assign walk_end  = OffW'(len_q) - OffW'(2);
  assign chan_addr = idx_q + OffW'(2) + OffW'({ch_q, 1'b0});
  assign at_limit  = (n_q == 7'(ResultLimit - 1));

  // Bytes beyond what the current frame stored read as zero.
  assign rbyte = rd_ok_q ? ram_rdata : 8'h00;

  assign len_eff   = (count_q == 8'd2) ? b : len_q;
  assign count_inc = {1'b0, count_q} + 9'd1;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    count_d   = count_q;
    len_d     = len_q;
    fid_d     = fid_q;
    prev_d    = prev_q;
    rcv_d     = rcv_q;
    end_d     = end_q;
    idx_d     = idx_q;
    next_d    = next_q;
    id_d      = id_q;
    ch_d      = ch_q;
    lo_d      = lo_q;
    n_d       = n_q;
    kind_d    = kind_q;
    val_d     = val_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    rd_addr   = idx_q;
    crc_start = 1'b0;
    crc_init  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (!phase_q) begin
            // Hunting: only a header byte opens a frame.
            if (b == HdrA || b == HdrB) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              count_d   = 8'd1;
              len_d     = 8'd0;
              phase_d   = 1'b1;
              end_d     = 1'b0;
              prev_d    = b;
              crc_start = 1'b1;
              crc_init  = 1'b1;
              state_d   = S_CRC;
            end
          end else begin
            ram_we = ({1'b0, count_q} < 9'(FRAME_BYTES));
            prev_d = b;
            if (count_q == 8'd3) begin
              fid_d = b;
            end
            if (count_q == 8'd2) begin
              len_d = b;
            end
            if (count_q == 8'd2 && (b < MinLength || {1'b0, b} > 9'(FRAME_BYTES))) begin
              // Impossible length: drop the frame and hunt again.
              phase_d = 1'b0;
              count_d = 8'd0;
            end else begin
              crc_start = (count_q < 8'd4) || (count_inc + 9'd1 < {1'b0, len_eff});
              state_d   = S_CRC;
              if (count_inc >= 9'd4 && count_inc >= {1'b0, len_eff}) begin
                phase_d = 1'b0;
                count_d = 8'd0;
                rcv_d   = {b, prev_q};
                end_d   = 1'b1;
              end else begin
                count_d = count_inc[7:0];
              end
            end
          end
        end
      end

      S_CRC: begin
        if (!crc_busy) begin
          state_d = S_IDLE;
          if (end_q) begin
            end_d = 1'b0;
            idx_d = OffW'(4);
            n_d   = 7'd0;
            if (crc == rcv_q && len_q > MinLength) begin
              state_d = S_W_ID;
            end
          end
        end
      end

      S_W_ID: begin
        rd_addr = idx_q;
        state_d = S_W_LEN;
      end

      S_W_LEN: begin
        id_d    = rbyte;
        rd_addr = idx_q + OffW'(1);
        state_d = S_W_BLK;
      end

      S_W_BLK: begin
        next_d = idx_q + OffW'(2) + OffW'(rbyte);
        ch_d   = 4'd0;
        val_d  = 16'h0000;
        if (id_q == BlkChannels) begin
          state_d = S_W_LO;
        end else begin
          unique case (id_q)
            BlkTelemetry: kind_d = EvTelemetry;
            BlkMenu:      kind_d = EvMenu;
            default:      kind_d = EvUnknown;
          endcase
          last_d  = at_limit || (next_d >= walk_end);
          state_d = S_EMIT;
        end
      end

      S_W_LO: begin
        rd_addr = chan_addr;
        state_d = S_W_HI;
      end

      S_W_HI: begin
        lo_d    = rbyte;
        rd_addr = chan_addr + OffW'(1);
        state_d = S_W_VAL;
      end

      S_W_VAL: begin
        kind_d  = EvChannel;
        val_d   = {rbyte, lo_q} - center_q;
        last_d  = at_limit ||
                  ((ch_q == 4'(CHANNEL_COUNT - 1)) && (next_q >= walk_end));
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_if.ready) begin
          n_d = n_q + 7'd1;
          if (last_q) begin
            state_d = S_IDLE;
          end else if (kind_q == EvChannel && ch_q != 4'(CHANNEL_COUNT - 1)) begin
            ch_d    = ch_q + 4'd1;
            state_d = S_W_LO;
          end else begin
            idx_d   = next_q;
            state_d = S_W_ID;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      center_q <= CenterReset;
      phase_q  <= 1'b0;
      count_q  <= 8'd0;
      len_q    <= 8'd0;
      end_q    <= 1'b0;
      n_q      <= 7'd0;
      ch_q     <= 4'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        center_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      end_q   <= end_d;
      n_q     <= n_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fid_q   <= fid_d;
    prev_q  <= prev_d;
    rcv_q   <= rcv_d;
    idx_q   <= idx_d;
    next_q  <= next_d;
    id_q    <= id_d;
    lo_q    <= lo_d;
    kind_q  <= kind_d;
    val_q   <= val_d;
    last_q  <= last_d;
    // Length mask: only offsets inside the finished frame were written.
    rd_ok_q <= (rd_addr < OffW'(len_q));
  end

  rcb_ram #(
    .Width (8),
    .Depth (FRAME_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (b),
    .raddr_i (rd_addr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  rcb_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crc_start),
    .init_i  (crc_init),
    .data_i  (b),
    .crc_o   (crc),
    .busy_o  (crc_busy)
  );

  assign out_if.valid         = (state_q == S_EMIT);
  assign out_if.event_kind    = kind_q;
  assign out_if.channel_index = (kind_q == EvChannel) ? ch_q : 4'd0;
  assign out_if.channel_value = val_q;
  assign out_if.frame_id      = fid_q;
  assign out_if.last_of_run   = last_q;
endmodule

[test/tb_rc_bus_frame_receiver.sv]
// Self-checking testbench for the bus frame receiver: directed frames, then random traffic.
module tb_rc_bus_frame_receiver;
  import rcb_pkg::*;

  localparam int unsigned FrameBytes = FrameBytesDef;
  localparam int unsigned ChanCount  = ChannelCountDef;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleGap  = 700;
  localparam int unsigned HoldCycles = 3000;
  localparam int unsigned PhaseBytes = 15;

  typedef struct packed {
    event_kind_e        kind;
    logic [3:0]         chan;
    logic signed [15:0] value;
    logic [7:0]         pid;
    logic               last;
  } bus_event_t;

  typedef enum int {
    RowNoise, RowBadLen, RowEmpty, RowBadCrc, RowTelem, RowMenu, RowUnknown,
    RowChannels, RowShortChan, RowManyTelem, RowCapped, RowFarBlock
  } row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] hdr;
    logic [7:0] ftype;
    logic [7:0] arg;
    int         exp_n;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  rcb_byte_if in_if ();
  rcb_evt_if  out_if ();

  rc_bus_frame_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the receiver state, kept in step with every accepted transfer.
  logic [15:0] center_q = CenterReset;
  logic        in_frame = 1'b0;
  logic [7:0]  frame_mem [FrameBytes];
  int          fill_cnt = 0;
  int          frame_len = 0;
  logic [15:0] crc_acc = '0;

  bus_event_t pending_events[$];
  logic [7:0] frame_q[$];
  logic [7:0] body_q[$];

  int fail_cnt = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int events_predicted = 0;
  int events_seen = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;

  stim_row_t rows [16];

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("MISMATCH: %s", msg);
  endtask

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] mem_at(input int idx);
    return (idx < FrameBytes) ? frame_mem[idx] : 8'h00;
  endfunction

  // Walks the blocks of a frame whose CRC matched and queues the events it yields.
  task automatic walk_frame_blocks();
    bus_event_t evs[$];
    bus_event_t ev;
    int idx;
    int blk_len;
    logic [7:0] id;
    logic [15:0] raw;
    idx = 4;
    while (idx < frame_len - 2 && evs.size() < 64) begin
      id = mem_at(idx);
      blk_len = mem_at(idx + 1);
      ev = '0;
      ev.pid = mem_at(3);
      if (id == BlkChannels) begin
        for (int i = 0; i < ChanCount; i++) begin
          raw = {mem_at(idx + 3 + 2 * i), mem_at(idx + 2 + 2 * i)};
          ev.kind = EvChannel;
          ev.chan = i[3:0];
          ev.value = raw - center_q;
          if (evs.size() < 64) evs.push_back(ev);
        end
      end else begin
        ev.kind = (id == BlkTelemetry) ? EvTelemetry : (id == BlkMenu) ? EvMenu : EvUnknown;
        evs.push_back(ev);
      end
      idx += 2 + blk_len;
    end
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
    events_predicted += evs.size();
  endtask

  task automatic track_rx_byte(input logic [7:0] b);
    logic [15:0] rx_crc;
    if (!in_frame) begin
      if (b == HdrA || b == HdrB) begin
        foreach (frame_mem[i]) frame_mem[i] = 8'h00;
        frame_mem[0] = b;
        fill_cnt = 1;
        frame_len = 0;
        crc_acc = crc_ccitt_step(16'h0000, b);
        in_frame = 1'b1;
      end
      return;
    end
    if (fill_cnt < FrameBytes) frame_mem[fill_cnt] = b;
    if (fill_cnt == 2) begin
      frame_len = b;
      if (b < MinLength || b > FrameBytes) begin
        in_frame = 1'b0;
        fill_cnt = 0;
        return;
      end
    end
    if (fill_cnt < 4 || fill_cnt + 2 < frame_len) crc_acc = crc_ccitt_step(crc_acc, b);
    fill_cnt++;
    if (fill_cnt >= 4 && fill_cnt >= frame_len) begin
      in_frame = 1'b0;
      fill_cnt = 0;
      rx_crc = {mem_at(frame_len - 1), mem_at(frame_len - 2)};
      if (rx_crc == crc_acc) walk_frame_blocks();
    end
  endtask

  // Offers one byte, with random idle cycles first, and tracks it once the transfer happens.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    track_rx_byte(b);
  endtask

  task automatic send_frame_q();
    foreach (frame_q[i]) push_byte(frame_q[i]);
    frames_sent++;
  endtask

  // Wraps body_q into a full frame with header, type, length, packet id and CRC.
  task automatic wrap_body(input logic [7:0] hdr, input logic [7:0] ftype,
                           input logic [7:0] pid, input bit bad_crc);
    logic [15:0] crc;
    frame_q = {hdr, ftype, 8'(body_q.size() + 6), pid};
    foreach (body_q[i]) frame_q.push_back(body_q[i]);
    crc = '0;
    foreach (frame_q[i]) crc = crc_ccitt_step(crc, frame_q[i]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  // The last byte must not stay offered while the sender waits.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_center(input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    center_q = val;
  endtask

  task automatic run_row(input stim_row_t r);
    int ev_base;
    ev_base = events_predicted;
    body_q = {};
    case (r.kind)
      RowNoise: frame_q = {r.arg};
      RowBadLen: frame_q = {r.hdr, r.ftype, r.arg};
      RowEmpty: wrap_body(r.hdr, r.ftype, r.arg, 1'b0);
      RowBadCrc: begin
        body_q = {BlkTelemetry, 8'h00};
        wrap_body(r.hdr, r.ftype, r.arg, 1'b1);
      end
      RowTelem, RowMenu, RowUnknown: begin
        body_q = {(r.kind == RowTelem) ? BlkTelemetry : (r.kind == RowMenu) ? BlkMenu : 8'h00,
                  8'h01, 8'h5a};
        wrap_body(r.hdr, r.ftype, r.arg, 1'b0);
      end
      RowChannels: begin
        // Raw words at zero, at full scale and at the center, the rest random.
        body_q = {BlkChannels, 8'd32, 8'h00, 8'h00, 8'hff, 8'hff, center_q[7:0], center_q[15:8]};
        repeat (26) body_q.push_back(8'($urandom));
        wrap_body(r.hdr, r.ftype, r.arg, 1'b0);
      end
      RowShortChan: begin
        body_q = {BlkChannels, 8'h02, 8'haa, 8'hbb};
        wrap_body(r.hdr, r.ftype, r.arg, 1'b0);
      end
      RowManyTelem, RowCapped: begin
        repeat (29) begin
          body_q.push_back((r.kind == RowManyTelem) ? BlkTelemetry : BlkChannels);
          body_q.push_back(8'h00);
        end
        wrap_body(r.hdr, r.ftype, r.arg, 1'b0);
      end
      default: begin
        // A block length that jumps far past the end of the frame.
        body_q = {BlkMenu, 8'hff, 8'h11, 8'h22};
        wrap_body(r.hdr, r.ftype, r.arg, 1'b0);
      end
    endcase
    send_frame_q();
    if (r.exp_n >= 0 && events_predicted - ev_base != r.exp_n)
      note_fail($sformatf("row %s: expected %0d events, shadow model gives %0d",
                          r.kind.name(), r.exp_n, events_predicted - ev_base));
  endtask

  // Mostly well-formed frames with random block mixes; some noise, bad lengths and bad CRCs.
  task automatic send_random_frame();
    int sel;
    int room;
    int blen;
    logic [7:0] hdr;
    hdr = $urandom_range(1) ? HdrA : HdrB;
    sel = $urandom_range(99);
    if (sel < 8) begin
      frame_q = {};
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      send_frame_q();
      return;
    end
    if (sel < 14) begin
      frame_q = {hdr, 8'($urandom), $urandom_range(1) ? 8'($urandom_range(5)) :
                 8'($urandom_range(255, 65))};
      send_frame_q();
      return;
    end
    body_q = {};
    room = ($urandom_range(9) == 0) ? 58 : $urandom_range(0, 36);
    while (body_q.size() < room) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        blen = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : 32;
        body_q.push_back(BlkChannels);
      end else begin
        blen = $urandom_range(0, 4);
        body_q.push_back(sel < 60 ? BlkTelemetry : sel < 75 ? BlkMenu : 8'($urandom));
      end
      body_q.push_back(8'(blen));
      repeat (blen) body_q.push_back(8'($urandom));
    end
    while (body_q.size() > room) void'(body_q.pop_back());
    wrap_body(hdr, 8'($urandom), 8'($urandom), $urandom_range(9) == 0);
    // Now and then a frame is cut short, so the next header lands inside it.
    if ($urandom_range(19) == 0) frame_q = frame_q[0:$urandom_range(frame_q.size() - 1)];
    send_frame_q();
  endtask

  // Output side: ready stalls at random, with a long hold-off when asked for.
  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Each event transfer is compared field by field with the oldest pending prediction.
  always @(posedge clk_i) begin
    bus_event_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        note_fail($sformatf("event with nothing pending: kind %0d ch %0d val %0d id %0h",
                            out_if.event_kind, out_if.channel_index, out_if.channel_value,
                            out_if.frame_id));
      end else begin
        want = pending_events.pop_front();
        if (out_if.event_kind !== want.kind || out_if.channel_index !== want.chan ||
            out_if.channel_value !== want.value || out_if.frame_id !== want.pid ||
            out_if.last_of_run !== want.last)
          note_fail($sformatf("expected k%0d c%0d v%0d id%0h l%0d, got k%0d c%0d v%0d id%0h l%0d",
                              want.kind, want.chan, want.value, want.pid, want.last,
                              out_if.event_kind, out_if.channel_index, out_if.channel_value,
                              out_if.frame_id, out_if.last_of_run));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("rc_bus_frame_receiver regression: fail");
      $finish;
    end
  end

  initial begin
    int phase_bytes;
    logic [15:0] centers [4];
    in_if.valid = 1'b0;
    in_if.rx_byte = '0;
    out_if.ready = 1'b0;
    rows = '{
      '{RowNoise,     HdrA, 8'h00, 8'h00, 0},
      '{RowNoise,     HdrA, 8'h00, 8'hff, 0},
      '{RowBadLen,    HdrA, 8'h00, 8'd5,  0},
      '{RowBadLen,    HdrB, 8'hff, 8'd0,  0},
      '{RowBadLen,    HdrA, 8'h01, 8'd65, 0},
      '{RowBadLen,    HdrB, 8'h80, 8'hff, 0},
      '{RowEmpty,     HdrA, 8'h00, 8'h12, 0},
      '{RowBadCrc,    HdrB, 8'h01, 8'h34, 0},
      '{RowTelem,     HdrA, 8'hff, 8'h00, 1},
      '{RowMenu,      HdrB, 8'h3a, 8'hff, 1},
      '{RowUnknown,   HdrA, 8'h3b, 8'h56, 1},
      '{RowChannels,  HdrB, 8'h55, 8'h78, 16},
      '{RowShortChan, HdrA, 8'haa, 8'h9a, 16},
      '{RowManyTelem, HdrB, 8'h0f, 8'hbc, 29},
      '{RowCapped,    HdrA, 8'hf0, 8'hde, 64},
      '{RowFarBlock,  HdrB, 8'h7e, 8'hef, 1}
    };
    centers = '{16'hffff, 16'h0000, 16'($urandom), CenterReset};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) run_row(rows[i]);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, then both.
    for (int ph = 0; ph < 4; ph++) begin
      write_center(centers[ph]);
      idle_pct = (ph == 1) ? 82 : (ph == 3) ? 23 : 0;
      stall_pct = (ph == 2) ? 82 : (ph == 3) ? 23 : 0;
      // The first phase opens with a long hold-off on the output while bytes keep coming.
      if (ph == 0) hold_go <= ~hold_go;
      phase_bytes = bytes_sent;
      while (bytes_sent - phase_bytes < PhaseBytes) send_random_frame();
      // Sender pauses here until every pending event has arrived.
      wait_drained();
    end

    $display("sent %0d bytes in %0d frames or fragments, %0d events checked",
             bytes_sent, frames_sent, events_seen);
    $display("four center settings, idle and stall mixes, plus a long output hold-off");
    if (fail_cnt == 0 && pending_events.size() == 0) begin
      $display("rc_bus_frame_receiver regression: pass");
    end else begin
      $display("%0d mismatches, %0d events still pending", fail_cnt, pending_events.size());
      $display("rc_bus_frame_receiver regression: fail");
    end
    $finish;
  end

endmodule
